[design/pid_controller_anti_windup_core_assert.svh]
// Assertion macros used by the checker file.
`ifndef PID_CONTROLLER_ANTI_WINDUP_CORE_ASSERT_SVH
`define PID_CONTROLLER_ANTI_WINDUP_CORE_ASSERT_SVH

// Assert a property on the rising clock edge, masked while reset is low.
`define PCA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on the rising clock edge, also during reset.
`define PCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pca_pkg.sv]
// Package: types, constants and saturating helpers of the PID controller core.
package pca_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int ADDR_BITS = 5;
  localparam int ONE       = 1 << FRAC_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        umag_t;
  typedef logic [WORD_BITS-2:0]        ubound_t;
  typedef logic [NUM_BITS-1:0]         num_t;

  localparam word_t W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam word_t LIM_DEAD  = word_t'(5 * ONE);
  localparam word_t LIM_H14   = word_t'(14 * ONE);
  localparam word_t LIM_H21   = word_t'(21 * ONE);
  localparam word_t LIM_H42   = word_t'(42 * ONE);
  localparam word_t LIM_ACCEL = word_t'(3000 * ONE);
  localparam word_t LIM_YAW   = word_t'(180 * ONE);
  localparam word_t YAW_TURN  = word_t'(360 * ONE);

  typedef enum logic [2:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_IBND  = 3'd3,
    REG_DBND  = 3'd4,
    REG_MSTEP = 3'd5,
    REG_DSRC  = 3'd6,
    REG_SHAPE = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    DSRC_ERR  = 2'd0,
    DSRC_MEAS = 2'd1,
    DSRC_RATE = 2'd2,
    DSRC_NONE = 2'd3
  } dsrc_e;

  typedef enum logic [1:0] {
    SHP_DEAD   = 2'd0,
    SHP_HEIGHT = 2'd1,
    SHP_ACCEL  = 2'd2,
    SHP_YAW    = 2'd3
  } shape_e;

  typedef enum logic {
    OPER_STEP  = 1'b0,
    OPER_CLEAR = 1'b1
  } oper_e;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic signed [31:0] measured_rate;
    logic [30:0]       time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic              integral_held;
  } out_word_t;

  typedef struct packed {
    word_t   prop_gain;
    word_t   integ_gain;
    word_t   deriv_gain;
    ubound_t integral_bound;
    ubound_t drive_bound;
    ubound_t min_step;
    dsrc_e   deriv_source;
    shape_e  error_shaping;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SHAPE,
    OP_DIV_START,
    OP_E_FROM_Q,
    OP_DNUM,
    OP_DSET,
    OP_D_FROM_Q,
    OP_MUL,
    OP_ACC_SET,
    OP_ACC_ADD,
    OP_TRIAL,
    OP_CHECK,
    OP_FINISH,
    OP_CLEAR
  } dp_op_e;

  typedef enum logic [2:0] {
    MUL_E_KP,
    MUL_D_KD,
    MUL_E_DT,
    MUL_TRIAL_KI,
    MUL_INTEG_KI
  } mul_sel_e;

  typedef enum logic [1:0] {
    NUM_E,
    NUM_E2,
    NUM_E3,
    NUM_D
  } num_sel_e;

  typedef enum logic [1:0] {
    DEN_3,
    DEN_5,
    DEN_100,
    DEN_STEP
  } den_sel_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e mul_sel;
    num_sel_e num_sel;
    den_sel_e den_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    shape_e shape;
    dsrc_e  dsrc;
    logic   e_accel_small;
    logic   e_lt14;
    logic   e_lt21;
    logic   div_zero;
    logic   ki_pos;
    logic   div_done;
    logic   out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_SHAPE,
    S_SDIV_WAIT,
    S_BAND,
    S_BDIV_WAIT,
    S_DNUM,
    S_DDIV,
    S_DDIV_WAIT,
    S_MUL_P,
    S_ACC_P,
    S_MUL_D,
    S_ACC_D,
    S_MUL_T,
    S_TRIAL,
    S_MUL_C,
    S_CHECK,
    S_MUL_I,
    S_ACC_I,
    S_FINISH
  } ctrl_state_e;

  function automatic word_t sadd(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? W_MIN : W_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t sneg(input word_t a);
    if (a == W_MIN) begin
      return W_MAX;
    end
    return -a;
  endfunction

  function automatic umag_t mag(input word_t a);
    if (a[WORD_BITS-1]) begin
      return umag_t'(-a);
    end
    return umag_t'(a);
  endfunction

  function automatic word_t sat_mag(input num_t m, input logic neg);
    if (neg) begin
      if (|m[NUM_BITS-1:WORD_BITS-1]) begin
        return W_MIN;
      end
      return word_t'(umag_t'(0) - m[WORD_BITS-1:0]);
    end
    if (|m[NUM_BITS-1:WORD_BITS-1]) begin
      return W_MAX;
    end
    return word_t'(m[WORD_BITS-1:0]);
  endfunction

endpackage

[design/pid_controller_anti_windup_core.sv]
// Top level of the PID controller core with integrator anti-windup.
//
//   channel   direction  handshake                   word
//   in        input      in_valid_i / in_stall_o     pca_pkg::in_word_t
//   out       output     out_valid_o / out_stall_i   pca_pkg::out_word_t
//   config    input      APB-style psel/penable      8 registers at 4*index
//
// One word at a time: the input stalls from acceptance until the controller is idle again.
// A clear word holds the core until the output is free. A step also waits on the
// one-bit-per-cycle divider when the derivative divides by the time step, on each constant
// divide of the error shaping and the integrator update if the integral gain is positive.
// Reset clears the integrator, previous term, last drive and all configuration registers.
// A stalled output word holds; a finished result waits for it before overwriting it.
module pid_controller_anti_windup_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pca_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pca_pkg::out_word_t            out_word_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pca_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pca_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  pca_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_oper_i  (in_word_i.operation),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pca_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

[design/pca_regs.sv]
// Configuration register bank behind the APB-style port.
module pca_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pca_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output pca_pkg::cfg_t                 cfg_o
);
  import pca_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_KP:    cfg_d.prop_gain      = word_t'(pwdata);
        REG_KI:    cfg_d.integ_gain     = word_t'(pwdata);
        REG_KD:    cfg_d.deriv_gain     = word_t'(pwdata);
        REG_IBND:  cfg_d.integral_bound = pwdata[30:0];
        REG_DBND:  cfg_d.drive_bound    = pwdata[30:0];
        REG_MSTEP: cfg_d.min_step       = pwdata[30:0];
        REG_DSRC:  cfg_d.deriv_source   = dsrc_e'(pwdata[1:0]);
        REG_SHAPE: cfg_d.error_shaping  = shape_e'(pwdata[1:0]);
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP:    prdata = cfg_q.prop_gain;
      REG_KI:    prdata = cfg_q.integ_gain;
      REG_KD:    prdata = cfg_q.deriv_gain;
      REG_IBND:  prdata = {1'b0, cfg_q.integral_bound};
      REG_DBND:  prdata = {1'b0, cfg_q.drive_bound};
      REG_MSTEP: prdata = {1'b0, cfg_q.min_step};
      REG_DSRC:  prdata = {30'b0, cfg_q.deriv_source};
      REG_SHAPE: prdata = {30'b0, cfg_q.error_shaping};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[design/pca_div.sv]
// Restoring divider, one quotient bit per cycle.
module pca_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  pca_pkg::num_t        num_i,
  input  pca_pkg::umag_t       den_i,
  output logic                 done_o,
  output pca_pkg::num_t        quot_o
);
  import pca_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS);

  num_t                 n_q, n_d;
  umag_t                rem_q, rem_d, den_q;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [WORD_BITS:0]   trial;

  assign trial  = {rem_q, n_q[NUM_BITS-1]};
  assign done_o = done_q;
  assign quot_o = n_q;

  always_comb begin
    n_d    = n_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = umag_t'(trial - {1'b0, den_q});
        n_d   = {n_q[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_d = trial[WORD_BITS-1:0];
        n_d   = {n_q[NUM_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_BITS'(NUM_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

endmodule

[design/pca_datapath.sv]
// Datapath: state words, shared multiplier, dividers and output register.
module pca_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pca_pkg::cfg_t       cfg_i,
  input  pca_pkg::in_word_t   in_word_i,
  input  pca_pkg::ctrl_cmd_t  cmd_i,
  output pca_pkg::dp_stat_t   stat_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output pca_pkg::out_word_t  out_word_o
);
  import pca_pkg::*;

  localparam umag_t RECIP_3   = 32'hAAAA_AAAB;
  localparam umag_t RECIP_5   = 32'hCCCC_CCCD;
  localparam umag_t RECIP_100 = 32'h51EB_851F;

  word_t     meas_q, rate_q, e_q, dnum_q, d_q, acc_q, trial_q;
  ubound_t   dt_q;
  word_t     integ_q, integ_d, prev_q, prev_d, last_q, last_d;
  logic      held_q;
  logic [2*WORD_BITS-1:0] prod_q;
  logic      prod_neg_q;
  out_word_t out_q;
  logic      out_valid_q, out_valid_d;
  num_t      cquot_q, cquot_d, sdiv_quot;
  logic      cdone_q, csel_q, sdiv_done, div_start;
  umag_t     crecip;
  logic [2*WORD_BITS-1:0] cprod;

  ubound_t   divisor;
  word_t     mq, mul_a, mul_b, e_shaped, chk_sum, drive_cl, nm;
  umag_t     e_mag, den_sel;
  num_t      num_sel, quot;
  logic      div_done, out_free, chk_ok;

  assign divisor = (dt_q > cfg_i.min_step) ? dt_q : cfg_i.min_step;
  assign e_mag   = mag(e_q);
  assign mq      = sat_mag(prod_q[2*WORD_BITS-1:FRAC_BITS], prod_neg_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign nm      = sneg(meas_q);

  always_comb begin
    case (cmd_i.num_sel)
      NUM_E:   num_sel = num_t'(e_mag);
      NUM_E2:  num_sel = num_t'({e_mag, 1'b0});
      NUM_E3:  num_sel = num_t'(e_mag) + num_t'({e_mag, 1'b0});
      NUM_D:   num_sel = {mag(dnum_q), {FRAC_BITS{1'b0}}};
      default: num_sel = '0;
    endcase
    case (cmd_i.den_sel)
      DEN_3:    den_sel = umag_t'(3);
      DEN_5:    den_sel = umag_t'(5);
      DEN_100:  den_sel = umag_t'(100);
      DEN_STEP: den_sel = umag_t'(divisor);
      default:  den_sel = umag_t'(1);
    endcase
  end

  // constant divides by reciprocal multiplication, exact for 32-bit numerators
  always_comb begin
    case (cmd_i.den_sel)
      DEN_3:   crecip = RECIP_3;
      DEN_5:   crecip = RECIP_5;
      DEN_100: crecip = RECIP_100;
      default: crecip = '0;
    endcase
    cprod = {umag_t'(0), num_sel[WORD_BITS-1:0]} * {umag_t'(0), crecip};
    case (cmd_i.den_sel)
      DEN_3:   cquot_d = num_t'(cprod[63:33]);
      DEN_5:   cquot_d = num_t'(cprod[63:34]);
      DEN_100: cquot_d = num_t'(cprod[63:37]);
      default: cquot_d = '0;
    endcase
  end

  assign div_start = (cmd_i.op == OP_DIV_START) && (cmd_i.den_sel == DEN_STEP);

  pca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_sel),
    .den_i   (den_sel),
    .done_o  (sdiv_done),
    .quot_o  (sdiv_quot)
  );

  assign quot     = csel_q ? cquot_q : sdiv_quot;
  assign div_done = sdiv_done || cdone_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_E_KP:     begin mul_a = e_q;     mul_b = cfg_i.prop_gain;  end
      MUL_D_KD:     begin mul_a = d_q;     mul_b = cfg_i.deriv_gain; end
      MUL_E_DT:     begin mul_a = e_q;     mul_b = word_t'({1'b0, dt_q}); end
      MUL_TRIAL_KI: begin mul_a = trial_q; mul_b = cfg_i.integ_gain; end
      MUL_INTEG_KI: begin mul_a = integ_q; mul_b = cfg_i.integ_gain; end
      default:      begin mul_a = '0;      mul_b = '0;               end
    endcase
  end

  always_comb begin
    case (cfg_i.error_shaping)
      SHP_DEAD:   e_shaped = (e_q < LIM_DEAD && e_q > -LIM_DEAD) ? '0 : e_q;
      SHP_HEIGHT: begin
        if (e_q > LIM_H42) begin
          e_shaped = LIM_H42;
        end else if (e_q < -LIM_H42) begin
          e_shaped = -LIM_H42;
        end else begin
          e_shaped = e_q;
        end
      end
      SHP_ACCEL:  e_shaped = (e_q < LIM_ACCEL && e_q > -LIM_ACCEL) ? '0 : e_q;
      SHP_YAW: begin
        if (e_q > LIM_YAW) begin
          e_shaped = e_q - YAW_TURN;
        end else if (e_q < -LIM_YAW) begin
          e_shaped = e_q + YAW_TURN;
        end else begin
          e_shaped = e_q;
        end
      end
      default:    e_shaped = e_q;
    endcase
  end

  assign chk_sum = sadd(acc_q, mq);
  assign chk_ok  = ((cfg_i.drive_bound == '0) ||
                    (mag(chk_sum) <= umag_t'(cfg_i.drive_bound))) &&
                   (mag(trial_q) <= umag_t'(cfg_i.integral_bound));

  always_comb begin
    drive_cl = acc_q;
    if (cfg_i.drive_bound != '0) begin
      if (acc_q > word_t'({1'b0, cfg_i.drive_bound})) begin
        drive_cl = word_t'({1'b0, cfg_i.drive_bound});
      end else if (acc_q < -word_t'({1'b0, cfg_i.drive_bound})) begin
        drive_cl = -word_t'({1'b0, cfg_i.drive_bound});
      end
    end
  end

  always_comb begin
    integ_d     = integ_q;
    prev_d      = prev_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (cmd_i.op)
      OP_DNUM: begin
        if (cfg_i.deriv_source == DSRC_ERR) begin
          prev_d = e_q;
        end else begin
          prev_d = nm;
        end
      end
      OP_CHECK: begin
        if (chk_ok) begin
          integ_d = trial_q;
        end
      end
      OP_FINISH: begin
        last_d      = drive_cl;
        out_valid_d = 1'b1;
      end
      OP_CLEAR: begin
        integ_d     = '0;
        out_valid_d = 1'b1;
      end
      default: begin
        integ_d = integ_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        meas_q <= in_word_i.measured;
        rate_q <= in_word_i.measured_rate;
        dt_q   <= in_word_i.time_step;
        e_q    <= sadd(in_word_i.setpoint, sneg(in_word_i.measured));
        held_q <= 1'b0;
      end
      OP_SHAPE:    e_q <= e_shaped;
      OP_DIV_START: begin
        cquot_q <= cquot_d;
        csel_q  <= (cmd_i.den_sel != DEN_STEP);
      end
      OP_E_FROM_Q: e_q <= sat_mag(quot, e_q[WORD_BITS-1]);
      OP_DNUM: begin
        if (cfg_i.deriv_source == DSRC_ERR) begin
          dnum_q <= sadd(e_q, sneg(prev_q));
        end else begin
          dnum_q <= sadd(nm, sneg(prev_q));
        end
      end
      OP_DSET:     d_q <= (cfg_i.deriv_source == DSRC_RATE) ? sneg(rate_q) : '0;
      OP_D_FROM_Q: d_q <= sat_mag(quot, dnum_q[WORD_BITS-1]);
      OP_MUL: begin
        prod_q     <= mag(mul_a) * mag(mul_b);
        prod_neg_q <= mul_a[WORD_BITS-1] ^ mul_b[WORD_BITS-1];
      end
      OP_ACC_SET:  acc_q <= mq;
      OP_ACC_ADD:  acc_q <= sadd(acc_q, mq);
      OP_TRIAL:    trial_q <= sadd(integ_q, mq);
      OP_CHECK:    held_q <= !chk_ok;
      OP_FINISH:   out_q <= '{drive: drive_cl, integral_held: held_q};
      OP_CLEAR:    out_q <= '{drive: last_q, integral_held: 1'b0};
      default:     acc_q <= acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      prev_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      cdone_q     <= 1'b0;
    end else begin
      integ_q     <= integ_d;
      prev_q      <= prev_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      cdone_q     <= (cmd_i.op == OP_DIV_START) && (cmd_i.den_sel != DEN_STEP);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign stat_o = '{
    shape:         cfg_i.error_shaping,
    dsrc:          cfg_i.deriv_source,
    e_accel_small: (e_q < LIM_ACCEL && e_q > -LIM_ACCEL),
    e_lt14:        (e_q < LIM_H14 && e_q > -LIM_H14),
    e_lt21:        (e_q < LIM_H21 && e_q > -LIM_H21),
    div_zero:      (divisor == '0),
    ki_pos:        (cfg_i.integ_gain > 0),
    div_done:      div_done,
    out_free:      out_free
  };

endmodule

[design/pca_ctrl.sv]
// Controller: sequences the datapath through one control step or one clear.
module pca_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_oper_i,
  output logic                in_stall_o,
  input  pca_pkg::dp_stat_t   stat_i,
  output pca_pkg::ctrl_cmd_t  cmd_o
);
  import pca_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '{op: OP_NONE, mul_sel: MUL_E_KP, num_sel: NUM_E, den_sel: DEN_3};
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (oper_e'(in_oper_i) == OPER_CLEAR) begin
            state_d = S_CLEAR;
          end else begin
            cmd_o.op = OP_LOAD;
            state_d  = S_SHAPE;
          end
        end
      end
      S_CLEAR: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_CLEAR;
          state_d  = S_IDLE;
        end
      end
      S_SHAPE: begin
        if (stat_i.shape == SHP_HEIGHT) begin
          cmd_o.op = OP_DIV_START;
          state_d  = S_SDIV_WAIT;
        end else if (stat_i.shape == SHP_ACCEL && !stat_i.e_accel_small) begin
          cmd_o.op      = OP_DIV_START;
          cmd_o.den_sel = DEN_100;
          state_d       = S_SDIV_WAIT;
        end else begin
          cmd_o.op = OP_SHAPE;
          state_d  = S_DNUM;
        end
      end
      S_SDIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_E_FROM_Q;
          state_d  = (stat_i.shape == SHP_HEIGHT) ? S_BAND : S_DNUM;
        end
      end
      S_BAND: begin
        if (stat_i.e_lt14) begin
          cmd_o.op      = OP_DIV_START;
          cmd_o.num_sel = NUM_E2;
          cmd_o.den_sel = DEN_5;
          state_d       = S_BDIV_WAIT;
        end else if (stat_i.e_lt21) begin
          cmd_o.op      = OP_DIV_START;
          cmd_o.num_sel = NUM_E3;
          cmd_o.den_sel = DEN_5;
          state_d       = S_BDIV_WAIT;
        end else begin
          cmd_o.op = OP_SHAPE;
          state_d  = S_DNUM;
        end
      end
      S_BDIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_E_FROM_Q;
          state_d  = S_DNUM;
        end
      end
      S_DNUM: begin
        if (stat_i.dsrc == DSRC_ERR || stat_i.dsrc == DSRC_MEAS) begin
          cmd_o.op = OP_DNUM;
          state_d  = S_DDIV;
        end else begin
          cmd_o.op = OP_DSET;
          state_d  = S_MUL_P;
        end
      end
      S_DDIV: begin
        if (stat_i.div_zero) begin
          cmd_o.op = OP_DSET;
          state_d  = S_MUL_P;
        end else begin
          cmd_o.op      = OP_DIV_START;
          cmd_o.num_sel = NUM_D;
          cmd_o.den_sel = DEN_STEP;
          state_d       = S_DDIV_WAIT;
        end
      end
      S_DDIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_D_FROM_Q;
          state_d  = S_MUL_P;
        end
      end
      S_MUL_P: begin
        cmd_o.op = OP_MUL;
        state_d  = S_ACC_P;
      end
      S_ACC_P: begin
        cmd_o.op = OP_ACC_SET;
        state_d  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.op      = OP_MUL;
        cmd_o.mul_sel = MUL_D_KD;
        state_d       = S_ACC_D;
      end
      S_ACC_D: begin
        cmd_o.op = OP_ACC_ADD;
        state_d  = stat_i.ki_pos ? S_MUL_T : S_FINISH;
      end
      S_MUL_T: begin
        cmd_o.op      = OP_MUL;
        cmd_o.mul_sel = MUL_E_DT;
        state_d       = S_TRIAL;
      end
      S_TRIAL: begin
        cmd_o.op = OP_TRIAL;
        state_d  = S_MUL_C;
      end
      S_MUL_C: begin
        cmd_o.op      = OP_MUL;
        cmd_o.mul_sel = MUL_TRIAL_KI;
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.op = OP_CHECK;
        state_d  = S_MUL_I;
      end
      S_MUL_I: begin
        cmd_o.op      = OP_MUL;
        cmd_o.mul_sel = MUL_INTEG_KI;
        state_d       = S_ACC_I;
      end
      S_ACC_I: begin
        cmd_o.op = OP_ACC_ADD;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/pca_chk.sv]
// Port checker for the PID controller core, bound to the top level.
`include "pid_controller_anti_windup_core_assert.svh"

module pca_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input pca_pkg::in_word_t             in_word_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input pca_pkg::out_word_t            out_word_o,
  input logic                          pready
);

  `PCA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "out dropped")
  `PCA_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(out_word_o), "out changed")
  `PCA_ASSERT(a_in_stable, clk_i, rst_ni, in_valid_i && in_stall_o |=> $stable(in_word_i), "in changed")
  `PCA_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "not busy")
  `PCA_ASSERT_ALWAYS(a_pready, clk_i, pready, "config port not ready")

endmodule

bind pid_controller_anti_windup_core pca_chk u_chk (.*);
